// ===== src/rewj_pkg.sv =====
// Package for the region extension block: payload words, configuration,
// the window memory entry, register indexes and the sequencer states.
// It depends on nothing else.
package rewj_pkg;

   localparam int IDX_W      = 16;
   localparam int LOADED_W   = 17;
   localparam int CUR_W      = 17;
   localparam int COUNT_W    = 10;
   localparam int JUMP_W     = 7;
   localparam int POS_W      = 32;
   localparam int TOTAL_W    = 26;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_COUNT      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_JUMP_DISTANCE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_POSITION = 2'd2;

   localparam logic [COUNT_W-1:0] MIN_COUNT_RESET = 10'd4;
   localparam logic [JUMP_W-1:0]  JUMP_RESET      = 7'd10;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [IDX_W-1:0]   window_index;
      logic [POS_W-1:0]   window_start;
      logic [POS_W-1:0]   window_end;
      logic [COUNT_W-1:0] site_count;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [POS_W-1:0]   region_start;
      logic [POS_W-1:0]   region_end;
      logic [TOTAL_W-1:0] region_total;
      logic [POS_W-1:0]   seed_start;
      logic [POS_W-1:0]   seed_end;
   } rsp_type;

   // Configuration as the sequencer sees it; jump is never zero here.
   typedef struct packed {
      logic [COUNT_W-1:0] min_count;
      logic [JUMP_W-1:0]  jump;
      logic [POS_W-1:0]   first_position;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0]   start;
      logic [POS_W-1:0]   stop;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEED,
      S_LEFT,
      S_RIGHT,
      S_FINISH
   } state_type;

endpackage

// ===== src/rewj_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Width and depth are parameters; no other file is needed.
module rewj_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rewj_ctrl.sv =====
// Sequencer of the region extension block: loads windows into the window
// memory, walks it for queries and holds the result word.
// Uses rewj_pkg; drives the ports of one rewj_ram.
module rewj_ctrl #(
   parameter int WINDOW_DEPTH = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rewj_pkg::cfg_type         cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rewj_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rewj_pkg::rsp_type         rsp_data,
   output logic                      ram_wr_en,
   output logic [$clog2(WINDOW_DEPTH)-1:0] ram_wr_addr,
   output logic [$bits(rewj_pkg::entry_type)-1:0] ram_wr_data,
   output logic                      ram_rd_en,
   output logic [$clog2(WINDOW_DEPTH)-1:0] ram_rd_addr,
   input  logic [$bits(rewj_pkg::entry_type)-1:0] ram_rd_data
);

   localparam int ADDR_W = $clog2(WINDOW_DEPTH);
   localparam logic [31:0] DEPTH_U = 32'(WINDOW_DEPTH);

   rewj_pkg::state_type state_ff, state_in;

   logic [rewj_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [rewj_pkg::CUR_W-1:0]    cur_ff, cur_in;
   logic [rewj_pkg::LOADED_W-1:0] loaded_ff, loaded_in;
   logic                          found_ff, found_in;
   logic [rewj_pkg::POS_W-1:0]    rstart_ff, rstart_in;
   logic [rewj_pkg::POS_W-1:0]    rend_ff, rend_in;
   logic [rewj_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [rewj_pkg::POS_W-1:0]    sstart_ff, sstart_in;
   logic [rewj_pkg::POS_W-1:0]    send_ff, send_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rewj_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   rewj_pkg::entry_type           rd_entry;
   rewj_pkg::entry_type           wr_entry;
   logic                          req_fire;
   logic                          is_query;
   logic                          seed_in_set;
   logic                          load_in_range;
   logic                          pass_left;
   logic                          pass_right;
   logic                          left_more;
   logic [rewj_pkg::CUR_W-1:0]    jump_ext;
   logic [rewj_pkg::CUR_W-1:0]    left_next;
   logic [rewj_pkg::CUR_W-1:0]    right_first;
   logic [rewj_pkg::CUR_W-1:0]    right_next;
   logic                          right_first_ok;
   logic                          right_next_ok;
   logic [rewj_pkg::TOTAL_W:0]    sum_wide;
   logic [rewj_pkg::TOTAL_W-1:0]  sum_sat;
   logic                          out_free;

   assign req_ready = (state_ff == rewj_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_query  = (req_data.mode == rewj_pkg::MODE_QUERY);

   assign load_in_range = (32'(req_data.window_index) < DEPTH_U);
   assign seed_in_set   = ({1'b0, req_data.window_index} < loaded_ff) && load_in_range;

   assign rd_entry = rewj_pkg::entry_type'(ram_rd_data);

   assign pass_right = (rd_entry.count >= cfg.min_count);
   assign pass_left  = pass_right && (rd_entry.start >= cfg.first_position);

   assign jump_ext    = rewj_pkg::CUR_W'(cfg.jump);
   assign left_more   = (cur_ff >= jump_ext);
   assign left_next   = cur_ff - jump_ext;
   assign right_first = {1'b0, idx_ff} + jump_ext;
   assign right_next  = cur_ff + jump_ext;
   assign right_first_ok = (right_first < loaded_ff) && (32'(right_first) < DEPTH_U);
   assign right_next_ok  = (right_next < loaded_ff) && (32'(right_next) < DEPTH_U);

   // Running total saturates at the top of its field.
   assign sum_wide = {1'b0, total_ff} + (rewj_pkg::TOTAL_W + 1)'(rd_entry.count);
   assign sum_sat  = sum_wide[rewj_pkg::TOTAL_W] ? rewj_pkg::TOTAL_MAX
                                                 : sum_wide[rewj_pkg::TOTAL_W-1:0];

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rewj_pkg::S_IDLE: begin
            if (req_fire && is_query) begin
               state_in = seed_in_set ? rewj_pkg::S_SEED : rewj_pkg::S_FINISH;
            end
         end
         rewj_pkg::S_SEED: begin
            if (!pass_left) begin
               state_in = rewj_pkg::S_FINISH;
            end else if (left_more) begin
               state_in = rewj_pkg::S_LEFT;
            end else if (right_first_ok) begin
               state_in = rewj_pkg::S_RIGHT;
            end else begin
               state_in = rewj_pkg::S_FINISH;
            end
         end
         rewj_pkg::S_LEFT: begin
            if (pass_left && left_more) begin
               state_in = rewj_pkg::S_LEFT;
            end else if (right_first_ok) begin
               state_in = rewj_pkg::S_RIGHT;
            end else begin
               state_in = rewj_pkg::S_FINISH;
            end
         end
         rewj_pkg::S_RIGHT: begin
            if (!(pass_right && right_next_ok)) begin
               state_in = rewj_pkg::S_FINISH;
            end
         end
         rewj_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = rewj_pkg::S_IDLE;
            end
         end
         default: state_in = rewj_pkg::S_IDLE;
      endcase
   end

   // Datapath, memory ports and result word.
   always_comb begin
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      loaded_in    = loaded_ff;
      found_in     = found_ff;
      rstart_in    = rstart_ff;
      rend_in      = rend_ff;
      total_in     = total_ff;
      sstart_in    = sstart_ff;
      send_in      = send_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      wr_entry.start = req_data.window_start;
      wr_entry.stop  = req_data.window_end;
      wr_entry.count = req_data.site_count;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ADDR_W'(req_data.window_index);
      ram_wr_data = wr_entry;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ADDR_W'(cur_ff);

      case (state_ff)
         rewj_pkg::S_IDLE: begin
            if (req_fire && !is_query && load_in_range) begin
               ram_wr_en = 1'b1;
               loaded_in = rewj_pkg::LOADED_W'({1'b0, req_data.window_index}) +
                           rewj_pkg::LOADED_W'(1);
            end
            if (req_fire && is_query) begin
               idx_in    = req_data.window_index;
               cur_in    = rewj_pkg::CUR_W'(req_data.window_index);
               found_in  = 1'b0;
               rstart_in = '0;
               rend_in   = '0;
               total_in  = '0;
               sstart_in = '0;
               send_in   = '0;
               ram_rd_en   = seed_in_set;
               ram_rd_addr = ADDR_W'(req_data.window_index);
            end
         end
         rewj_pkg::S_SEED: begin
            if (pass_left) begin
               found_in  = 1'b1;
               sstart_in = rd_entry.start;
               send_in   = rd_entry.stop;
               rstart_in = rd_entry.start;
               rend_in   = rd_entry.stop;
               total_in  = sum_sat;
               cur_in    = left_more ? left_next : right_first;
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(cur_in);
            end
         end
         rewj_pkg::S_LEFT: begin
            if (pass_left) begin
               rstart_in = rd_entry.start;
               total_in  = sum_sat;
               cur_in    = left_more ? left_next : right_first;
            end else begin
               cur_in = right_first;
            end
            ram_rd_en   = 1'b1;
            ram_rd_addr = ADDR_W'(cur_in);
         end
         rewj_pkg::S_RIGHT: begin
            if (pass_right) begin
               rend_in  = rd_entry.stop;
               total_in = sum_sat;
               cur_in   = right_next;
            end
            ram_rd_en   = 1'b1;
            ram_rd_addr = ADDR_W'(cur_in);
         end
         rewj_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.found        = found_ff;
               rsp_data_in.region_start = rstart_ff;
               rsp_data_in.region_end   = rend_ff;
               rsp_data_in.region_total = total_ff;
               rsp_data_in.seed_start   = sstart_ff;
               rsp_data_in.seed_end     = send_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rewj_pkg::S_IDLE;
         loaded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cur_ff      <= cur_in;
      found_ff    <= found_in;
      rstart_ff   <= rstart_in;
      rend_ff     <= rend_in;
      total_ff    <= total_in;
      sstart_ff   <= sstart_in;
      send_ff     <= send_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_left_below_seed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rewj_pkg::S_LEFT) |-> (cur_ff < {1'b0, idx_ff}))
      else $error("left walk is not below the seed window");

   a_right_inside_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rewj_pkg::S_RIGHT) |-> (cur_ff < loaded_ff))
      else $error("right walk reads beyond the loaded windows");

   a_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == rewj_pkg::S_IDLE))
      else $error("window memory written during a walk");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |->
         (rsp_data_ff.region_start == '0 && rsp_data_ff.region_end == '0 &&
          rsp_data_ff.region_total == '0 && rsp_data_ff.seed_start == '0 &&
          rsp_data_ff.seed_end == '0))
      else $error("result word without a region carries nonzero fields");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == rewj_pkg::S_FINISH))
      else $error("result word raised outside the finish step");
`endif

endmodule

// ===== src/region_extension_by_window_jumps.sv =====
// Region extension by window jumps. A load word (mode 0) writes one window
// into the window memory when accepted, if its index is within the depth.
// A query word (mode 1) reads the seed window, walks left and then right in
// steps of the jump distance and raises the result word from the finish
// step once the output register is free. A seed that does not qualify ends
// the walk at once, and a seed outside the loaded set goes straight to the
// finish step. Windows are read one at a time through the single registered
// read port of the window memory, and the next word is accepted once the
// result sits in the output register. Uses rewj_pkg, rewj_ram and rewj_ctrl.
module region_extension_by_window_jumps #(
   parameter int WINDOW_DEPTH = 65536
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  rewj_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rewj_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rewj_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rewj_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int ADDR_W  = $clog2(WINDOW_DEPTH);
   localparam int ENTRY_W = $bits(rewj_pkg::entry_type);

   logic [rewj_pkg::COUNT_W-1:0] min_count_ff, min_count_in;
   logic [rewj_pkg::JUMP_W-1:0]  jump_ff, jump_in;
   logic [rewj_pkg::POS_W-1:0]   first_pos_ff, first_pos_in;
   rewj_pkg::cfg_type            cfg;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      min_count_in = min_count_ff;
      jump_in      = jump_ff;
      first_pos_in = first_pos_ff;
      if (csr_valid) begin
         case (csr_index)
            rewj_pkg::CSR_MIN_COUNT:
               min_count_in = csr_wdata[rewj_pkg::COUNT_W-1:0];
            rewj_pkg::CSR_JUMP_DISTANCE:
               jump_in = csr_wdata[rewj_pkg::JUMP_W-1:0];
            rewj_pkg::CSR_FIRST_POSITION:
               first_pos_in = csr_wdata[rewj_pkg::POS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_count_ff <= rewj_pkg::MIN_COUNT_RESET;
         jump_ff      <= rewj_pkg::JUMP_RESET;
         first_pos_ff <= '0;
      end else begin
         min_count_ff <= min_count_in;
         jump_ff      <= jump_in;
         first_pos_ff <= first_pos_in;
      end
   end

   // A jump distance of zero steps by one window.
   assign cfg.min_count      = min_count_ff;
   assign cfg.jump           = (jump_ff == '0) ? rewj_pkg::JUMP_W'(1) : jump_ff;
   assign cfg.first_position = first_pos_ff;

   rewj_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rewj_ctrl #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule
